// File: sv/lcdw_pkg.sv
// lcdw_pkg: shared constants, payload types and the converter status struct
// for the decimal nibble writer. No dependencies.

package lcdw_pkg;

   localparam int DIGITS       = 5;
   localparam int TOTAL_BYTES  = 4 * (DIGITS + 1);
   localparam int IDX_W        = $clog2(TOTAL_BYTES);
   localparam int BYTE_IDX_W   = IDX_W - 2;
   localparam int CNT_W        = $clog2(DIGITS + 1);
   localparam int DIG_IDX_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam int NUMBER_W     = 16;
   localparam int POSITION_W   = 7;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] SET_ADDRESS = 8'h80;

   // n / 10 == (n * 52429) >> 19 for every 16-bit n
   localparam logic [31:0] DIV10_MULT  = 32'd52429;
   localparam int          DIV10_SHIFT = 19;

   localparam int          CSR_ADDR_W  = 3;
   localparam int          CSR_DATA_W  = 32;
   localparam logic [0:0]  REG_BACKLIGHT = 1'b0;

   typedef struct packed {
      logic [NUMBER_W-1:0]   number;
      logic [POSITION_W-1:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic                        done;
      logic [POSITION_W-1:0]       position;
      logic [DIGITS-1:0][3:0]      digits;
   } conv_status_type;

endpackage

// File: sv/lcdw_bin2dec.sv
// lcdw_bin2dec: takes one input word and peels off its decimal digits, one per
// cycle, least significant first. Depends on lcdw_pkg.

module lcdw_bin2dec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  lcdw_pkg::req_payload_type req_payload,
   output logic                    req_stall,
   input  logic                    take,
   output lcdw_pkg::conv_status_type status
);
   import lcdw_pkg::*;

   logic                         busy_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [NUMBER_W-1:0]          rem_ff;
   logic [POSITION_W-1:0]        pos_ff;
   logic [DIGITS-1:0][3:0]       dig_ff;

   logic [31:0]                  prod;
   logic [NUMBER_W-1:0]          quot;
   logic [NUMBER_W-1:0]          quot_x10;
   logic [NUMBER_W-1:0]          digit_full;
   logic                         done;
   logic                         accept;

   assign done      = busy_ff && (cnt_ff == CNT_W'(DIGITS));
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   assign prod       = 32'(rem_ff) * DIV10_MULT;
   assign quot       = NUMBER_W'(prod >> DIV10_SHIFT);
   assign quot_x10   = (quot << 3) + (quot << 1);
   assign digit_full = rem_ff - quot_x10;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (take) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && !done) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // digits shift toward the top so the most significant ends at index 0
   always_ff @(posedge clock) begin
      if (accept) begin
         rem_ff <= req_payload.number;
         pos_ff <= req_payload.position;
      end else if (busy_ff && !done) begin
         rem_ff <= quot;
         for (int i = DIGITS - 1; i > 0; i--) begin
            dig_ff[i] <= dig_ff[i-1];
         end
         dig_ff[0] <= digit_full[3:0];
      end
   end

   assign status.done     = done;
   assign status.position = pos_ff;
   assign status.digits   = dig_ff;

endmodule

// File: sv/lcd_decimal_nibble_writer.sv
// lcd_decimal_nibble_writer: top level with register port, byte sequencer and
// output register. Depends on lcdw_pkg and lcdw_bin2dec.
//
// Usage: each word on the req_ channel (number, position) becomes 24 words on
// the rsp_ channel: the set-address instruction then five ASCII digits with
// leading zeros, each display byte split into four expander bytes (high
// nibble with enable set and cleared, then the low nibble likewise). last
// marks the 24th word. Throughput is one rsp word per cycle while rsp_stall
// is low, so one req word per 24 rsp words; the limit is the single output
// register. The digit converter runs one digit per cycle while the previous
// word's bytes are still going out. req_stall is high while the converter
// holds a word. When rsp_stall is high with a word in the output register,
// the register holds it and the sequencer pauses; nothing is lost. Reset
// (synchronous, active high) empties all stages and sets backlight_on to 1.
// The csr_ port is APB-style with pready always high; backlight_on lies at
// address 0.

module lcd_decimal_nibble_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  lcdw_pkg::req_payload_type           req_payload,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output lcdw_pkg::rsp_payload_type           rsp_payload,
   input  logic                                rsp_stall,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcdw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lcdw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lcdw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import lcdw_pkg::*;

   logic                      backlight_ff;
   logic                      em_busy_ff;
   logic [IDX_W-1:0]          em_idx_ff;
   logic [POSITION_W-1:0]     em_pos_ff;
   logic [DIGITS-1:0][3:0]    em_dig_ff;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff;

   conv_status_type           cv;
   logic                      em_fire;
   logic                      last_fire;
   logic                      xfer;
   logic [BYTE_IDX_W-1:0]     byte_idx;
   logic [BYTE_IDX_W-1:0]     dig_pos;
   logic [3:0]                digit;
   logic [7:0]                disp_byte;
   logic [3:0]                nibble;
   logic                      csr_write;
   rsp_payload_type           rsp_payload_in;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b1;
      end else if (csr_write && (csr_paddr[2] == REG_BACKLIGHT)) begin
         backlight_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_BACKLIGHT) ?
                       {{(CSR_DATA_W-1){1'b0}}, backlight_ff} : '0;

   lcdw_bin2dec u_conv (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .take        (xfer),
      .status      (cv)
   );

   // sequencer
   assign em_fire   = em_busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_fire = em_fire && (em_idx_ff == IDX_W'(TOTAL_BYTES - 1));
   assign xfer      = cv.done && (!em_busy_ff || last_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff <= 1'b0;
         em_idx_ff  <= '0;
      end else if (xfer) begin
         em_busy_ff <= 1'b1;
         em_idx_ff  <= '0;
      end else if (last_fire) begin
         em_busy_ff <= 1'b0;
      end else if (em_fire) begin
         em_idx_ff <= em_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         em_pos_ff <= cv.position;
         em_dig_ff <= cv.digits;
      end
   end

   // byte 0 is the instruction, byte k > 0 is digit k-1 (most significant first)
   assign byte_idx = em_idx_ff[IDX_W-1:2];
   assign dig_pos  = byte_idx - BYTE_IDX_W'(1);
   assign digit    = em_dig_ff[dig_pos[DIG_IDX_W-1:0]];

   always_comb begin
      if (byte_idx == '0) begin
         disp_byte = SET_ADDRESS | {1'b0, em_pos_ff};
      end else begin
         disp_byte = ASCII_ZERO + {4'b0000, digit};
      end
      nibble = em_idx_ff[1] ? disp_byte[3:0] : disp_byte[7:4];
      rsp_payload_in.expander_byte = {nibble, backlight_ff, !em_idx_ff[0], 1'b0,
                                      (byte_idx != '0)};
      rsp_payload_in.last = (em_idx_ff == IDX_W'(TOTAL_BYTES - 1));
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (em_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (em_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sim/testbench.sv
// testbench for lcd_decimal_nibble_writer: drives numbers and display positions,
// predicts every expander byte and checks the rsp words in order.
// Depends on lcdw_pkg and the RTL of the block.

module testbench;
   import lcdw_pkg::*;

   localparam logic [7:0] NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] ENABLE_MASK = 8'h04;
   localparam logic [CSR_ADDR_W-1:0] BACKLIGHT_ADDR = CSR_ADDR_W'(4 * REG_BACKLIGHT);
   localparam int HOLD_CYCLES = 400;
   // longest legal quiet stretch is the long receiver hold, plus a few stalls
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 88;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_payload_type req_payload = '0;
   logic req_stall;
   logic rsp_valid;
   rsp_payload_type rsp_payload;
   logic rsp_stall = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   rsp_payload_type pending_bytes[$];
   logic backlight_copy = 1'b1;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   lcd_decimal_nibble_writer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_payload(req_payload),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // expected expander bytes for one printed number
   function automatic void predict_display_bytes(input logic [NUMBER_W-1:0] number,
                                                 input logic [POSITION_W-1:0] position);
      logic [7:0] chars[DIGITS+1];
      logic [7:0] ctl;
      logic [7:0] hi;
      logic [7:0] lo;
      int value;
      rsp_payload_type word;
      chars[0] = SET_ADDRESS | {1'b0, position};
      value = number;
      for (int d = DIGITS; d >= 1; d--) begin
         chars[d] = ASCII_ZERO + 8'(value % 10);
         value = value / 10;
      end
      for (int k = 0; k <= DIGITS; k++) begin
         ctl = {4'b0000, backlight_copy, 1'b1, 1'b0, k != 0};
         hi = (chars[k] & NIBBLE_MASK) | ctl;
         lo = ({chars[k][3:0], 4'b0000}) | ctl;
         word.last = 1'b0;
         word.expander_byte = hi;
         pending_bytes.push_back(word);
         word.expander_byte = hi & ~ENABLE_MASK;
         pending_bytes.push_back(word);
         word.expander_byte = lo;
         pending_bytes.push_back(word);
         word.expander_byte = lo & ~ENABLE_MASK;
         word.last = (k == DIGITS);
         pending_bytes.push_back(word);
      end
   endfunction

   // rsp side: random stall, or a long hold when the pressure test asks
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected rsp word: expander_byte %h last %b",
                   rsp_payload.expander_byte, rsp_payload.last);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_payload.expander_byte !== want.expander_byte) begin
               $error("expander_byte: expected %h, got %h",
                      want.expander_byte, rsp_payload.expander_byte);
               mismatch_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_payload.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // entered and left at a rising edge
   task automatic send_word(input logic [NUMBER_W-1:0] number,
                            input logic [POSITION_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{number: number, position: position};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_display_bytes(number, position);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic read_backlight(input logic want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= BACKLIGHT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== want) begin
         $error("backlight_on: expected %b, got %b", want, csr_prdata[0]);
         mismatch_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_backlight(input logic value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= BACKLIGHT_ADDR;
      csr_pwdata <= {$urandom} & ~32'h1 | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      backlight_copy = value;
      @(posedge clock);
      read_backlight(value);
      @(posedge clock);
   endtask

   function automatic logic [NUMBER_W-1:0] pick_number();
      case ($urandom_range(3))
         0: return NUMBER_W'($urandom_range(9));
         1: return NUMBER_W'($urandom_range(999));
         2: return NUMBER_W'($urandom_range(65535, 60000));
         default: return NUMBER_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_value();
      read_backlight(1'b1);
      @(posedge clock);
   endtask

   task automatic test_directed();
      logic [NUMBER_W-1:0] numbers[12] = '{0, 65535, 9999, 10000, 12345, 1, 54321,
                                           16'h8000, 16'h5555, 16'hAAAA, 60909, 10};
      logic [POSITION_W-1:0] places[6] = '{0, 127, 7'h40, 7'h2A, 7'h55, 1};
      send_idle_pct = 0;
      stall_pct = 0;
      foreach (numbers[i]) send_word(numbers[i], places[i % 6]);
      drain_and_settle();
      write_backlight(1'b0);
      foreach (places[i]) send_word(numbers[(i * 5) % 12], places[i]);
      drain_and_settle();
   endtask

   task automatic test_random_phases();
      int send_table[4] = '{0, 82, 0, 37};
      int stall_table[4] = '{0, 0, 82, 37};
      for (int p = 0; p < 4; p++) begin
         write_backlight(p[0] ? 1'b0 : 1'b1);
         send_idle_pct = send_table[p];
         stall_pct = stall_table[p];
         repeat (PHASE_ITEMS) send_word(pick_number(), POSITION_W'($urandom));
         drain_and_settle();
      end
   endtask

   // receiver holds off long enough for the block to fill and stall req
   task automatic test_backpressure();
      write_backlight(1'b1);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (20) send_word(NUMBER_W'($urandom), POSITION_W'($urandom));
      drain_and_settle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_directed();
      test_random_phases();
      test_backpressure();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
